FILE: rtl/srarq_pkg.sv
// Shared types, codes and constants of the selective-repeat ARQ control core.
package srarq_pkg;

  localparam int MAX_SEQUENCE    = 15;
  localparam int SEQ_W           = 4;
  localparam int SEQ_CNT         = MAX_SEQUENCE + 1;
  localparam int WINDOW_SIZE_DEF = 8;
  localparam int RESULT_CAP      = 27;

  typedef logic [SEQ_W-1:0] seq_t;

  typedef enum logic [2:0] {
    KIND_NEW_PACKET   = 3'd0,
    KIND_PHY_READY    = 3'd1,
    KIND_FRAME        = 3'd2,
    KIND_ACK_TIMEOUT  = 3'd3,
    KIND_DATA_TIMEOUT = 3'd4
  } kind_t;

  localparam logic [1:0] FT_DATA = 2'd0;
  localparam logic [1:0] FT_NAK  = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_SEND_DATA = 3'd1,
    ACT_SEND_ACK  = 3'd2,
    ACT_SEND_NAK  = 3'd3,
    ACT_STORE     = 3'd4,
    ACT_DELIVER   = 3'd5,
    ACT_START_ACK = 3'd6,
    ACT_STOP_DATA = 3'd7
  } act_t;

  typedef struct packed {
    act_t action;
    seq_t seq;
    seq_t ack;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } emit_t;

  typedef struct packed {
    logic start;
    logic enable;
  } play_t;

  function automatic seq_t seq_next(input seq_t k);
    return (k == seq_t'(MAX_SEQUENCE)) ? seq_t'(0) : seq_t'(k + seq_t'(1));
  endfunction

  function automatic seq_t seq_prev(input seq_t k);
    return (k == seq_t'(0)) ? seq_t'(MAX_SEQUENCE) : seq_t'(k - seq_t'(1));
  endfunction

endpackage

FILE: rtl/selective_repeat_arq_control_top.sv
// Top level of the selective-repeat ARQ control core: stream ports, sequencer and result buffer.
// An accepted event passes a dispatch step, the walk steps (ack-or-nak choice, store check, nak
// request check, each delivery and its ack timer, each stopped data timer, the closing check of
// each walk) and a finish step; results then follow, one per cycle while m_tready is high.
// Only one event is in flight; s_tready returns after the last result transfer.
// Reset (rst, synchronous, active high) empties the windows and result buffer at once.
module selective_repeat_arq_control_top #(
  parameter int WINDOW_SIZE = srarq_pkg::WINDOW_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // frame_good[0], frame_type[2:1], frame_seq[6:3], peer_ack[10:7], timer_number[14:11]
  input  logic [15:0] s_tdata,
  // kind[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // seq_out[3:0], ack_out[7:4], network_enable[8]
  output logic [15:0] m_tdata,
  // action[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  srarq_pkg::emit_t  emit;
  srarq_pkg::play_t  play;
  srarq_pkg::entry_t out_entry;
  logic              busy;
  logic              out_enable;

  srarq_seq #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .kind         (s_tuser),
    .frame_good   (s_tdata[0]),
    .frame_type   (s_tdata[2:1]),
    .frame_seq    (s_tdata[6:3]),
    .peer_ack     (s_tdata[10:7]),
    .timer_number (s_tdata[14:11]),
    .emit         (emit),
    .play         (play),
    .out_busy     (busy)
  );

  srarq_rbuf u_rbuf (
    .clk        (clk),
    .rst        (rst),
    .emit       (emit),
    .play       (play),
    .busy       (busy),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_entry  (out_entry),
    .out_enable (out_enable),
    .out_last   (m_tlast)
  );

  assign m_tuser = out_entry.action;
  assign m_tdata = {7'b0, out_enable, out_entry.ack, out_entry.seq};

endmodule

FILE: rtl/srarq_win.sv
// Shared circular window compare unit: is b within [a, c) modulo the sequence space.
module srarq_win (
  input  srarq_pkg::seq_t a,
  input  srarq_pkg::seq_t b,
  input  srarq_pkg::seq_t c,
  output logic            hit
);

  logic a_le_b;
  logic b_lt_c;
  logic c_lt_a;

  assign a_le_b = (a <= b);
  assign b_lt_c = (b < c);
  assign c_lt_a = (c < a);
  assign hit    = (a_le_b && b_lt_c) || (c_lt_a && a_le_b) || (b_lt_c && c_lt_a);

endmodule

FILE: rtl/srarq_seq.sv
// Event sequencer: window state, arrived marks and the command walks over one shared compare.
module srarq_seq #(
  parameter int WINDOW_SIZE = srarq_pkg::WINDOW_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic               frame_good,
  input  logic [1:0]         frame_type,
  input  srarq_pkg::seq_t    frame_seq,
  input  srarq_pkg::seq_t    peer_ack,
  input  srarq_pkg::seq_t    timer_number,
  output srarq_pkg::emit_t   emit,
  output srarq_pkg::play_t   play,
  input  logic               out_busy
);

  localparam int BW = $clog2(WINDOW_SIZE + 1);
  localparam int MW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int GMAX = (WINDOW_SIZE > srarq_pkg::SEQ_CNT) ? WINDOW_SIZE : srarq_pkg::SEQ_CNT;
  localparam int GW = $clog2(GMAX + 1);
  localparam srarq_pkg::seq_t RUE_RESET =
    srarq_pkg::seq_t'(WINDOW_SIZE % srarq_pkg::SEQ_CNT);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_EVENT    = 10'b0000000010,
    S_DATA     = 10'b0000000100,
    S_STORE    = 10'b0000001000,
    S_DELIVER  = 10'b0000010000,
    S_STARTACK = 10'b0000100000,
    S_NAKREQ   = 10'b0001000000,
    S_ACKWALK  = 10'b0010000000,
    S_FINISH   = 10'b0100000000,
    S_PLAY     = 10'b1000000000
  } state_t;

  state_t state, state_next;

  srarq_pkg::seq_t sle, sle_next;
  srarq_pkg::seq_t nsn, nsn_next;
  srarq_pkg::seq_t rle, rle_next;
  srarq_pkg::seq_t rue, rue_next;
  logic [BW-1:0]   buffered, buffered_next;
  logic [WINDOW_SIZE-1:0] marks, marks_next;
  logic            nak_allowed, nak_allowed_next;
  logic            phys, phys_next;
  logic [GW-1:0]   guard, guard_next;
  logic            any_emit, any_emit_next;

  logic [2:0]      kind_r;
  logic            good_r;
  logic [1:0]      type_r;
  srarq_pkg::seq_t seq_r;
  srarq_pkg::seq_t ack_r;
  srarq_pkg::seq_t timer_r;

  logic [MW-1:0]   mark_tbl [srarq_pkg::SEQ_CNT];
  logic [MW-1:0]   mark_addr;
  srarq_pkg::seq_t ack_now;
  srarq_pkg::seq_t want;
  srarq_pkg::seq_t win_a, win_b, win_c;
  logic            win_hit;

  for (genvar i = 0; i < srarq_pkg::SEQ_CNT; i++) begin : g_mark_tbl
    assign mark_tbl[i] = MW'(i % WINDOW_SIZE);
  end

  assign mark_addr = (state == S_STORE) ? mark_tbl[seq_r] : mark_tbl[rle];
  assign ack_now   = srarq_pkg::seq_prev(rle);
  assign want      = srarq_pkg::seq_next(ack_r);
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    case (state)
      S_STORE: begin
        win_a = rle;
        win_b = seq_r;
        win_c = rue;
      end
      S_NAKREQ: begin
        win_a = sle;
        win_b = want;
        win_c = nsn;
      end
      default: begin
        win_a = sle;
        win_b = ack_r;
        win_c = nsn;
      end
    endcase
  end

  srarq_win u_win (
    .a   (win_a),
    .b   (win_b),
    .c   (win_c),
    .hit (win_hit)
  );

  always_comb begin
    state_next       = state;
    sle_next         = sle;
    nsn_next         = nsn;
    rle_next         = rle;
    rue_next         = rue;
    buffered_next    = buffered;
    marks_next       = marks;
    nak_allowed_next = nak_allowed;
    phys_next        = phys;
    guard_next       = guard;
    emit             = '0;
    play             = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EVENT;
        end
      end
      S_EVENT: begin
        state_next = S_FINISH;
        case (kind_r)
          srarq_pkg::KIND_NEW_PACKET: begin
            if (buffered < BW'(WINDOW_SIZE)) begin
              buffered_next      = buffered + BW'(1);
              emit.valid         = 1'b1;
              emit.entry.action  = srarq_pkg::ACT_SEND_DATA;
              emit.entry.seq     = nsn;
              emit.entry.ack     = ack_now;
              nsn_next           = srarq_pkg::seq_next(nsn);
              phys_next          = 1'b0;
            end
          end
          srarq_pkg::KIND_PHY_READY: begin
            phys_next = 1'b1;
          end
          srarq_pkg::KIND_FRAME: begin
            if (!good_r) begin
              if (nak_allowed) begin
                emit.valid        = 1'b1;
                emit.entry.action = srarq_pkg::ACT_SEND_NAK;
                emit.entry.ack    = ack_now;
                nak_allowed_next  = 1'b0;
                phys_next         = 1'b0;
              end
            end else if (type_r == srarq_pkg::FT_DATA) begin
              state_next = S_DATA;
            end else if (type_r == srarq_pkg::FT_NAK) begin
              state_next = S_NAKREQ;
            end else begin
              guard_next = '0;
              state_next = S_ACKWALK;
            end
          end
          srarq_pkg::KIND_ACK_TIMEOUT: begin
            emit.valid        = 1'b1;
            emit.entry.action = srarq_pkg::ACT_SEND_ACK;
            emit.entry.ack    = ack_now;
            phys_next         = 1'b0;
          end
          srarq_pkg::KIND_DATA_TIMEOUT: begin
            emit.valid        = 1'b1;
            emit.entry.action = srarq_pkg::ACT_SEND_DATA;
            emit.entry.seq    = timer_r;
            emit.entry.ack    = ack_now;
            phys_next         = 1'b0;
          end
          default: begin
          end
        endcase
      end
      S_DATA: begin
        emit.valid = 1'b1;
        if (seq_r != rle && nak_allowed) begin
          emit.entry.action = srarq_pkg::ACT_SEND_NAK;
          emit.entry.ack    = ack_now;
          nak_allowed_next  = 1'b0;
          phys_next         = 1'b0;
        end else begin
          emit.entry.action = srarq_pkg::ACT_START_ACK;
        end
        state_next = S_STORE;
      end
      S_STORE: begin
        guard_next = '0;
        if (win_hit && !marks[mark_addr]) begin
          marks_next[mark_addr] = 1'b1;
          emit.valid            = 1'b1;
          emit.entry.action     = srarq_pkg::ACT_STORE;
          emit.entry.seq        = seq_r;
          state_next            = S_DELIVER;
        end else begin
          state_next = S_ACKWALK;
        end
      end
      S_DELIVER: begin
        if (guard < GW'(WINDOW_SIZE) && marks[mark_addr]) begin
          emit.valid            = 1'b1;
          emit.entry.action     = srarq_pkg::ACT_DELIVER;
          emit.entry.seq        = rle;
          nak_allowed_next      = 1'b1;
          marks_next[mark_addr] = 1'b0;
          rle_next              = srarq_pkg::seq_next(rle);
          rue_next              = srarq_pkg::seq_next(rue);
          guard_next            = guard + GW'(1);
          state_next            = S_STARTACK;
        end else begin
          guard_next = '0;
          state_next = S_ACKWALK;
        end
      end
      S_STARTACK: begin
        emit.valid        = 1'b1;
        emit.entry.action = srarq_pkg::ACT_START_ACK;
        state_next        = S_DELIVER;
      end
      S_NAKREQ: begin
        if (win_hit) begin
          emit.valid        = 1'b1;
          emit.entry.action = srarq_pkg::ACT_SEND_DATA;
          emit.entry.seq    = want;
          emit.entry.ack    = ack_now;
          phys_next         = 1'b0;
        end
        guard_next = '0;
        state_next = S_ACKWALK;
      end
      S_ACKWALK: begin
        if (guard <= GW'(srarq_pkg::MAX_SEQUENCE) && win_hit) begin
          if (buffered != '0) begin
            buffered_next = buffered - BW'(1);
          end
          emit.valid        = 1'b1;
          emit.entry.action = srarq_pkg::ACT_STOP_DATA;
          emit.entry.seq    = sle;
          sle_next          = srarq_pkg::seq_next(sle);
          guard_next        = guard + GW'(1);
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!any_emit) begin
          emit.valid        = 1'b1;
          emit.entry.action = srarq_pkg::ACT_NONE;
        end
        play.start  = 1'b1;
        play.enable = (buffered < BW'(WINDOW_SIZE)) && phys;
        state_next  = S_PLAY;
      end
      S_PLAY: begin
        if (!out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign any_emit_next = (state == S_IDLE) ? 1'b0 : (any_emit || emit.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sle         <= '0;
      nsn         <= '0;
      rle         <= '0;
      rue         <= RUE_RESET;
      buffered    <= '0;
      marks       <= '0;
      nak_allowed <= 1'b1;
      phys        <= 1'b0;
      guard       <= '0;
      any_emit    <= 1'b0;
    end else begin
      state       <= state_next;
      sle         <= sle_next;
      nsn         <= nsn_next;
      rle         <= rle_next;
      rue         <= rue_next;
      buffered    <= buffered_next;
      marks       <= marks_next;
      nak_allowed <= nak_allowed_next;
      phys        <= phys_next;
      guard       <= guard_next;
      any_emit    <= any_emit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      kind_r  <= kind;
      good_r  <= frame_good;
      type_r  <= frame_type;
      seq_r   <= frame_seq;
      ack_r   <= peer_ack;
      timer_r <= timer_number;
    end
  end

  a_buffered_bound: assert property (@(posedge clk) disable iff (rst)
    buffered <= BW'(WINDOW_SIZE))
    else $error("buffered count above window size");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> (state != S_IDLE && state != S_PLAY))
    else $error("command produced outside an event");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_EVENT))
    else $error("accepted transfer did not start an event");

  a_play_follows: assert property (@(posedge clk) disable iff (rst)
    play.start |=> (state == S_PLAY && out_busy))
    else $error("playback did not start after finish");

endmodule

FILE: rtl/srarq_rbuf.sv
// Result buffer: collects the commands of one event and plays them out with enable and last.
module srarq_rbuf (
  input  logic               clk,
  input  logic               rst,
  input  srarq_pkg::emit_t   emit,
  input  srarq_pkg::play_t   play,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output srarq_pkg::entry_t  out_entry,
  output logic               out_enable,
  output logic               out_last
);

  localparam int AW = $clog2(srarq_pkg::RESULT_CAP);
  localparam int CW = $clog2(srarq_pkg::RESULT_CAP + 1);

  srarq_pkg::entry_t mem [srarq_pkg::RESULT_CAP];

  logic [CW-1:0] wr_cnt;
  logic [CW-1:0] rd_ptr;
  logic          playing;
  logic          wr_en;
  logic          load;
  logic          drained;

  assign wr_en   = emit.valid && (wr_cnt < CW'(srarq_pkg::RESULT_CAP));
  assign load    = playing && (!out_valid || out_ready) && (rd_ptr != wr_cnt);
  assign drained = playing && (rd_ptr == wr_cnt) && (!out_valid || out_ready);
  assign busy    = playing;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_cnt[AW-1:0]] <= emit.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_entry <= mem[rd_ptr[AW-1:0]];
      out_last  <= ((rd_ptr + CW'(1)) == wr_cnt);
    end
    if (play.start) begin
      out_enable <= play.enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_cnt    <= '0;
      rd_ptr    <= '0;
      playing   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_cnt <= wr_cnt + CW'(1);
      end
      if (play.start) begin
        playing <= 1'b1;
        rd_ptr  <= '0;
      end
      if (load) begin
        out_valid <= 1'b1;
        rd_ptr    <= rd_ptr + CW'(1);
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (drained) begin
        playing <= 1'b0;
        wr_cnt  <= '0;
      end
    end
  end

  a_valid_in_play: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> playing)
    else $error("result shown outside playback");

  a_no_fill_in_play: assert property (@(posedge clk) disable iff (rst)
    (emit.valid || play.start) |-> !playing)
    else $error("buffer written during playback");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (rd_ptr == wr_cnt))
    else $error("last result shown before buffer end");

endmodule

FILE: verif/srarq_command_checker.sv
// Checker for the ARQ control core: predicts the command run of each event and compares it.
module srarq_command_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // frame_good[0], frame_type[2:1], frame_seq[6:3], peer_ack[10:7], timer_number[14:11]
  input  logic [15:0] s_tdata,
  // kind[2:0]
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // seq_out[3:0], ack_out[7:4], network_enable[8]
  input  logic [15:0] m_tdata,
  // action[2:0]
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          pending,
  output int          commands,
  output int          deliveries
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = srarq_pkg::WINDOW_SIZE_DEF;

  typedef struct packed {
    srarq_pkg::act_t action;
    srarq_pkg::seq_t seq;
    srarq_pkg::seq_t ack;
    logic            net_en;
    logic            fin;
  } cmd_t;

  cmd_t want_cmds[$];
  cmd_t run[$];

  srarq_pkg::seq_t snd_lo;
  srarq_pkg::seq_t snd_next;
  srarq_pkg::seq_t rcv_lo;
  srarq_pkg::seq_t rcv_hi;
  int              out_cnt;
  logic            arrived [WIN];
  logic            nak_ok;
  logic            phy_rdy;

  function automatic logic in_span(srarq_pkg::seq_t a, srarq_pkg::seq_t b, srarq_pkg::seq_t c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  task automatic report(string msg);
    $display("%0t ns checker: %s", $time, msg);
    errors++;
  endtask

  task automatic add_cmd(srarq_pkg::act_t a, srarq_pkg::seq_t s, srarq_pkg::seq_t k);
    cmd_t c;
    c.action = a;
    c.seq    = s;
    c.ack    = k;
    c.net_en = 1'b0;
    c.fin    = 1'b0;
    if (run.size() < srarq_pkg::RESULT_CAP) run.push_back(c);
  endtask

  // Every frame put on the line carries the receive edge minus one and uses up the line.
  task automatic issue(srarq_pkg::act_t a, srarq_pkg::seq_t s);
    add_cmd(a, s, srarq_pkg::seq_t'(rcv_lo - 1'b1));
    if (a == srarq_pkg::ACT_SEND_NAK) nak_ok = 1'b0;
    phy_rdy = 1'b0;
  endtask

  task automatic take_frame(logic good, logic [1:0] ftype, srarq_pkg::seq_t fseq,
                            srarq_pkg::seq_t fack);
    int              n;
    srarq_pkg::seq_t want;
    if (!good) begin
      if (nak_ok) issue(srarq_pkg::ACT_SEND_NAK, '0);
      return;
    end
    if (ftype == srarq_pkg::FT_DATA) begin
      if (fseq != rcv_lo && nak_ok) issue(srarq_pkg::ACT_SEND_NAK, '0);
      else add_cmd(srarq_pkg::ACT_START_ACK, '0, '0);
      if (in_span(rcv_lo, fseq, rcv_hi) && !arrived[int'(fseq) % WIN]) begin
        arrived[int'(fseq) % WIN] = 1'b1;
        add_cmd(srarq_pkg::ACT_STORE, fseq, '0);
        for (n = 0; n < WIN && arrived[int'(rcv_lo) % WIN]; n++) begin
          add_cmd(srarq_pkg::ACT_DELIVER, rcv_lo, '0);
          nak_ok = 1'b1;
          arrived[int'(rcv_lo) % WIN] = 1'b0;
          rcv_lo = srarq_pkg::seq_t'(rcv_lo + 1'b1);
          rcv_hi = srarq_pkg::seq_t'(rcv_hi + 1'b1);
          add_cmd(srarq_pkg::ACT_START_ACK, '0, '0);
        end
      end
    end
    if (ftype == srarq_pkg::FT_NAK) begin
      want = srarq_pkg::seq_t'(fack + 1'b1);
      if (in_span(snd_lo, want, snd_next)) issue(srarq_pkg::ACT_SEND_DATA, want);
    end
    for (n = 0; n < srarq_pkg::SEQ_CNT && in_span(snd_lo, fack, snd_next); n++) begin
      if (out_cnt > 0) out_cnt--;
      add_cmd(srarq_pkg::ACT_STOP_DATA, snd_lo, '0);
      snd_lo = srarq_pkg::seq_t'(snd_lo + 1'b1);
    end
  endtask

  task automatic predict_commands(logic [2:0] kind, logic [15:0] data);
    logic en;
    int   k;
    run.delete();
    case (kind)
      srarq_pkg::KIND_NEW_PACKET: begin
        if (out_cnt < WIN) begin
          out_cnt++;
          issue(srarq_pkg::ACT_SEND_DATA, snd_next);
          snd_next = srarq_pkg::seq_t'(snd_next + 1'b1);
        end
      end
      srarq_pkg::KIND_PHY_READY: begin
        phy_rdy = 1'b1;
      end
      srarq_pkg::KIND_FRAME: begin
        take_frame(data[0], data[2:1], data[6:3], data[10:7]);
      end
      srarq_pkg::KIND_ACK_TIMEOUT: begin
        issue(srarq_pkg::ACT_SEND_ACK, '0);
      end
      srarq_pkg::KIND_DATA_TIMEOUT: begin
        issue(srarq_pkg::ACT_SEND_DATA, data[14:11]);
      end
      default: begin
      end
    endcase
    if (run.size() == 0) add_cmd(srarq_pkg::ACT_NONE, '0, '0);
    en = (out_cnt < WIN) && phy_rdy;
    for (k = 0; k < run.size(); k++) begin
      run[k].net_en = en;
      run[k].fin    = (k == run.size() - 1);
      want_cmds.push_back(run[k]);
    end
  endtask

  task automatic check_command();
    cmd_t due;
    commands++;
    if (m_tuser == srarq_pkg::ACT_DELIVER) deliveries++;
    if (want_cmds.size() == 0) begin
      report($sformatf("command transfer action %0d with nothing outstanding", m_tuser));
      return;
    end
    due = want_cmds.pop_front();
    if (m_tuser !== due.action)
      report($sformatf("action %0d, expected %0d", m_tuser, due.action));
    if (m_tdata[3:0] !== due.seq)
      report($sformatf("seq_out %0d, expected %0d", m_tdata[3:0], due.seq));
    if (m_tdata[7:4] !== due.ack)
      report($sformatf("ack_out %0d, expected %0d", m_tdata[7:4], due.ack));
    if (m_tdata[8] !== due.net_en)
      report($sformatf("network_enable %b, expected %b", m_tdata[8], due.net_en));
    if (m_tlast !== due.fin)
      report($sformatf("tlast %b, expected %b", m_tlast, due.fin));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      snd_lo     = '0;
      snd_next   = '0;
      rcv_lo     = '0;
      rcv_hi     = srarq_pkg::seq_t'(WIN);
      out_cnt    = 0;
      nak_ok     = 1'b1;
      phy_rdy    = 1'b0;
      errors     = 0;
      commands   = 0;
      deliveries = 0;
      for (int i = 0; i < WIN; i++) arrived[i] = 1'b0;
      want_cmds.delete();
    end else begin
      if (s_tvalid && s_tready) predict_commands(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_command();
    end
    pending = want_cmds.size();
  end

endmodule

FILE: verif/tb_selective_repeat_arq_control_top.sv
// Testbench top for the ARQ control core: clock, reset, event stimulus and the verdict.
module tb_selective_repeat_arq_control_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         WIN        = srarq_pkg::WINDOW_SIZE_DEF;
  localparam int         RAND_ITEMS = 400;
  localparam int         STALL_MAX  = 2000;
  localparam logic [1:0] FT_ACK     = 2'd1;
  localparam logic [1:0] FT_ODD     = 2'd3;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  int              errors;
  int              pending;
  int              commands;
  int              deliveries;
  int              n_events  = 0;
  int              idle_run  = 0;
  logic            calm      = 1'b0;
  srarq_pkg::seq_t tx_lo     = '0;
  srarq_pkg::seq_t tx_next   = '0;
  srarq_pkg::seq_t peer_next = '0;

  selective_repeat_arq_control_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  srarq_command_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .errors     (errors),
    .pending    (pending),
    .commands   (commands),
    .deliveries (deliveries)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= STALL_MAX) begin
      $display("No transfer for %0d cycles.", STALL_MAX);
      $display("tb_selective_repeat_arq_control_top NOT OK");
      $finish;
    end
  end

  function automatic logic [15:0] pack(logic good, logic [1:0] ftype, srarq_pkg::seq_t fseq,
                                       srarq_pkg::seq_t fack, srarq_pkg::seq_t tnum);
    return {1'b0, tnum, fack, fseq, ftype, good};
  endfunction

  // Mostly an acknowledgement inside our send window, so that timers get stopped.
  function automatic srarq_pkg::seq_t pick_ack();
    srarq_pkg::seq_t span;
    int              r;
    span = srarq_pkg::seq_t'(tx_next - tx_lo);
    r    = $urandom_range(0, 9);
    if (span != 0 && r < 7) return srarq_pkg::seq_t'(tx_lo + $urandom_range(0, span - 1));
    if (r < 9) return srarq_pkg::seq_t'(tx_lo - 1'b1);
    return srarq_pkg::seq_t'($urandom);
  endfunction

  task automatic put_event(logic [2:0] kind, logic [15:0] data);
    int              gap;
    srarq_pkg::seq_t fack;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 7) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    n_events++;
    // Follow the send window and the peer's sequence so that later items stay well formed.
    if (kind == srarq_pkg::KIND_NEW_PACKET && srarq_pkg::seq_t'(tx_next - tx_lo) < WIN)
      tx_next = srarq_pkg::seq_t'(tx_next + 1'b1);
    if (kind == srarq_pkg::KIND_FRAME && data[0]) begin
      fack = data[10:7];
      if (data[2:1] == srarq_pkg::FT_DATA && data[6:3] == peer_next)
        peer_next = srarq_pkg::seq_t'(peer_next + 1'b1);
      if (srarq_pkg::seq_t'(fack - tx_lo) < srarq_pkg::seq_t'(tx_next - tx_lo))
        tx_lo = srarq_pkg::seq_t'(fack + 1'b1);
    end
  endtask

  initial begin
    int              n_items;
    int              n_directed;
    int              r;
    logic [2:0]      kind;
    logic [15:0]     data;
    logic            full;
    srarq_pkg::seq_t fseq;
    logic [1:0]      ftype;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    put_event(srarq_pkg::KIND_PHY_READY, pack(1'b0, srarq_pkg::FT_DATA, 4'd0, 4'd0, 4'd0));
    repeat (WIN) begin
      put_event(srarq_pkg::KIND_NEW_PACKET, pack(1'b0, srarq_pkg::FT_DATA, 4'd0, 4'd0, 4'd0));
    end
    put_event(srarq_pkg::KIND_NEW_PACKET, pack(1'b1, FT_ODD, 4'd15, 4'd15, 4'd15));
    put_event(srarq_pkg::KIND_FRAME, pack(1'b1, FT_ACK, 4'd0, 4'd7, 4'd15));
    put_event(srarq_pkg::KIND_FRAME, pack(1'b1, srarq_pkg::FT_DATA, 4'd0, 4'd7, 4'd0));
    put_event(srarq_pkg::KIND_FRAME, pack(1'b1, srarq_pkg::FT_DATA, 4'd2, 4'd7, 4'd0));
    put_event(srarq_pkg::KIND_FRAME, pack(1'b1, srarq_pkg::FT_DATA, 4'd1, 4'd7, 4'd0));
    put_event(srarq_pkg::KIND_FRAME, pack(1'b0, srarq_pkg::FT_DATA, 4'd3, 4'd7, 4'd0));
    put_event(srarq_pkg::KIND_FRAME, pack(1'b0, srarq_pkg::FT_NAK, 4'd15, 4'd15, 4'd15));
    put_event(srarq_pkg::KIND_DATA_TIMEOUT, pack(1'b0, srarq_pkg::FT_DATA, 4'd0, 4'd0, 4'd15));
    put_event(srarq_pkg::KIND_ACK_TIMEOUT, pack(1'b0, srarq_pkg::FT_DATA, 4'd0, 4'd0, 4'd0));
    put_event(srarq_pkg::KIND_NEW_PACKET, pack(1'b0, srarq_pkg::FT_DATA, 4'd0, 4'd0, 4'd0));
    put_event(srarq_pkg::KIND_FRAME, pack(1'b1, srarq_pkg::FT_NAK, 4'd0, 4'd7, 4'd0));
    put_event(srarq_pkg::KIND_FRAME, pack(1'b1, FT_ODD, 4'd0, 4'd8, 4'd0));
    put_event(KIND_SPARE_LO, pack(1'b1, srarq_pkg::FT_DATA, 4'd3, 4'd8, 4'd0));
    put_event(KIND_SPARE_HI, pack(1'b1, FT_ODD, 4'd15, 4'd15, 4'd15));
    put_event(srarq_pkg::KIND_FRAME, pack(1'b1, srarq_pkg::FT_DATA, 4'd15, 4'd15, 4'd0));
    n_directed = n_events;

    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      calm  = (n_items >= 150 && n_items < 230);
      r     = $urandom_range(0, 99);
      data  = {1'b0, 15'($urandom)};
      if (r < 25) begin
        kind = srarq_pkg::KIND_NEW_PACKET;
      end else if (r < 38) begin
        kind = srarq_pkg::KIND_PHY_READY;
      end else if (r < 60) begin
        kind = srarq_pkg::KIND_FRAME;
        r    = $urandom_range(0, 19);
        if (r < 15) fseq = peer_next;
        else if (r < 18) fseq = srarq_pkg::seq_t'(peer_next + $urandom_range(1, 3));
        else fseq = srarq_pkg::seq_t'($urandom);
        data = pack($urandom_range(0, 9) != 0, srarq_pkg::FT_DATA, fseq, pick_ack(),
                    srarq_pkg::seq_t'($urandom));
      end else if (r < 75) begin
        kind  = srarq_pkg::KIND_FRAME;
        ftype = ($urandom_range(0, 9) == 0) ? FT_ODD : FT_ACK;
        data  = pack($urandom_range(0, 9) != 0, ftype, srarq_pkg::seq_t'($urandom), pick_ack(),
                     srarq_pkg::seq_t'($urandom));
      end else if (r < 83) begin
        kind = srarq_pkg::KIND_FRAME;
        data = pack($urandom_range(0, 9) != 0, srarq_pkg::FT_NAK, srarq_pkg::seq_t'($urandom),
                    srarq_pkg::seq_t'(pick_ack() - 1'b1), srarq_pkg::seq_t'($urandom));
      end else if (r < 89) begin
        kind = srarq_pkg::KIND_ACK_TIMEOUT;
      end else if (r < 95) begin
        kind = srarq_pkg::KIND_DATA_TIMEOUT;
      end else begin
        kind = 3'($urandom_range(0, 7));
      end
      full = (kind == srarq_pkg::KIND_NEW_PACKET) && (srarq_pkg::seq_t'(tx_next - tx_lo) >= WIN);
      put_event(kind, data);
      if (!full && kind <= srarq_pkg::KIND_DATA_TIMEOUT) n_items++;
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Ran %0d events (%0d directed), checked %0d command transfers.",
             n_events, n_directed, commands);
    $display("Receive side delivered %0d frames in order; %0d mismatches.", deliveries, errors);
    if (errors == 0 && pending == 0) begin
      $display("tb_selective_repeat_arq_control_top OK");
    end else begin
      $display("tb_selective_repeat_arq_control_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/srarq_pkg.sv
rtl/srarq_win.sv
rtl/srarq_seq.sv
rtl/srarq_rbuf.sv
rtl/selective_repeat_arq_control_top.sv
verif/srarq_command_checker.sv
verif/tb_selective_repeat_arq_control_top.sv
